FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i while out of reset.
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Check that a condition never holds on a rising edge of clk_i.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_AT(lbl, !(cond))

`endif

FILE: rtl/srtf_pkg.sv
// Package with sizes and result codes of the SRTF scheduler.
`timescale 1ns / 1ps
package srtf_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned UNITS_W = 32;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned IN_DATA_W  = 24;  // proc_id + burst
  localparam int unsigned OUT_DATA_W = 48;  // run_id + finished + units_done + pad

  typedef enum logic [STAT_W-1:0] {
    ST_RAN    = 2'd0,
    ST_IDLE   = 2'd1,
    ST_ACCEPT = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } command_e;

endpackage

FILE: rtl/srtf_scheduler_unit.sv
// Shortest-remaining-time-first scheduler over a slot table held in a synchronous memory.
//
// Input beats (s_axis): tuser carries the command (arrival or tick), tdata carries the
// arriving process id and its burst length. Output beats (m_axis): tuser carries the
// status (ran, idle, arrival accepted, arrival rejected), tdata the id that ran, the
// finished flag and the running count of executed units. Every input beat yields
// exactly one output beat.
// Owner id and remaining time of each slot live in one memory with a registered read;
// the valid bits live in flip-flops. An arrival writes the lowest free slot in the cycle
// it is accepted; its result goes to the pending-result register, then to the output register.
// A tick sweeps the memory one slot per cycle through the single read port, keeps the
// running minimum, then writes the decremented entry back if a live slot was found.
// One item is in work at a time; the next beat is taken as soon as the block returns to
// idle, while the previous result may still sit unclaimed in the output register. If the
// receiver stalls, the finished result waits in a holding register and the block stops
// there until the output register frees up.
// Reset clears every valid bit, the unit counter and all handshake state; memory
// contents are left as they are and are ignored while their valid bit is clear.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srtf_scheduler_unit
  import srtf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // [7:0] proc_id, [23:8] burst
  input  logic                  s_axis_tuser_i,   // [0] command
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // [7:0] run_id, [8] finished,
                                                  // [40:9] units_done, [47:41] zero
  output logic [STAT_W-1:0]     m_axis_tuser_o    // [1:0] status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WB,
    S_EMIT
  } state_e;

  localparam int unsigned ENT_W = ID_W + BURST_W;

  state_e              state_q;
  logic [SLOTS-1:0]    slot_valid_q;
  logic [UNITS_W-1:0]  units_q;
  logic [SLOT_W-1:0]   scan_idx_q;
  logic                rd_pend_q;
  logic [SLOT_W-1:0]   rd_idx_q;
  logic [ENT_W-1:0]    rd_data_q;
  logic                found_q;
  logic [SLOT_W-1:0]   best_idx_q;
  logic [ID_W-1:0]     best_owner_q;
  logic [BURST_W-1:0]  best_rem_q;

  // Pending result, then the output register.
  status_e             res_status_q;
  logic [ID_W-1:0]     res_id_q;
  logic                res_fin_q;
  logic                m_valid_q;
  status_e             m_status_q;
  logic [ID_W-1:0]     m_id_q;
  logic                m_fin_q;
  logic [UNITS_W-1:0]  m_units_q;

  logic [ENT_W-1:0]    slot_mem_q [SLOTS];

  logic                in_fire;
  logic                out_free;
  logic [ID_W-1:0]     in_id;
  logic [BURST_W-1:0]  in_burst;
  logic                free_hit;
  logic [SLOT_W-1:0]   free_idx;
  logic                arrive_ok;
  logic                cand_take;
  logic [ID_W-1:0]     rd_owner;
  logic [BURST_W-1:0]  rd_rem;
  logic [BURST_W-1:0]  best_rem_dec;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  logic [ENT_W-1:0]    mem_wdata;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign in_id           = s_axis_tdata_i[ID_W-1:0];
  assign in_burst        = s_axis_tdata_i[ID_W+BURST_W-1:ID_W];

  // Lowest free slot: walk down so the lowest clear bit wins.
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!slot_valid_q[k]) begin
        free_hit = 1'b1;
        free_idx = SLOT_W'(k);
      end
    end
  end

  assign arrive_ok = free_hit && (in_burst != '0);

  // Compare stage of the sweep: strict less-than keeps ties on the lower slot.
  assign rd_owner  = rd_data_q[ENT_W-1:BURST_W];
  assign rd_rem    = rd_data_q[BURST_W-1:0];
  assign cand_take = rd_pend_q && slot_valid_q[rd_idx_q] &&
                     (!found_q || (rd_rem < best_rem_q));
  assign best_rem_dec = best_rem_q - BURST_W'(1);

  // Single write port: arrival fill or tick write-back, never in the same cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = {in_id, in_burst};
    if (in_fire && (s_axis_tuser_i == CMD_ARRIVE) && arrive_ok) begin
      mem_we = 1'b1;
    end else if ((state_q == S_WB) && found_q) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx_q;
      mem_wdata = {best_owner_q, best_rem_dec};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= slot_mem_q[scan_idx_q];
  end

  // Sequencer, valid bits, counter and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slot_valid_q <= '0;
      units_q      <= '0;
      scan_idx_q   <= '0;
      rd_pend_q    <= 1'b0;
      found_q      <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == S_SCAN);
      // Load a new beat when the output register frees up, else drop a taken one.
      if ((state_q == S_EMIT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser_i == CMD_TICK) begin
              scan_idx_q <= '0;
              found_q    <= 1'b0;
              state_q    <= S_SCAN;
            end else begin
              if (arrive_ok) begin
                slot_valid_q[free_idx] <= 1'b1;
              end
              state_q <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          if (cand_take) begin
            found_q <= 1'b1;
          end
          scan_idx_q <= scan_idx_q + SLOT_W'(1);
          if (scan_idx_q == SLOT_W'(SLOTS - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // Last read returns here; fold it into the minimum.
          if (cand_take) begin
            found_q <= 1'b1;
          end
          state_q <= S_WB;
        end
        S_WB: begin
          if (found_q) begin
            units_q <= units_q + UNITS_W'(1);
            if (best_rem_q == BURST_W'(1)) begin
              slot_valid_q[best_idx_q] <= 1'b0;
            end
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers: running minimum, pending result, output beat.
  always_ff @(posedge clk_i) begin
    if (cand_take) begin
      best_idx_q   <= rd_idx_q;
      best_owner_q <= rd_owner;
      best_rem_q   <= rd_rem;
    end
    rd_idx_q <= scan_idx_q;
    if (in_fire && (s_axis_tuser_i == CMD_ARRIVE)) begin
      res_status_q <= arrive_ok ? ST_ACCEPT : ST_REJECT;
      res_id_q     <= '0;
      res_fin_q    <= 1'b0;
    end else if (state_q == S_WB) begin
      res_status_q <= found_q ? ST_RAN : ST_IDLE;
      res_id_q     <= found_q ? best_owner_q : '0;
      res_fin_q    <= found_q && (best_rem_q == BURST_W'(1));
    end
    if ((state_q == S_EMIT) && out_free) begin
      m_status_q <= res_status_q;
      m_id_q     <= res_id_q;
      m_fin_q    <= res_fin_q;
      m_units_q  <= units_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - ID_W - 1 - UNITS_W)'(0), m_units_q, m_fin_q, m_id_q};

  // A slot picked by the sweep must still be live at write-back.
  `ASSERT_AT(a_pick_live, ((state_q == S_WB) && found_q) |-> slot_valid_q[best_idx_q])
  // A tick that ran a process advances the unit count by exactly one.
  `ASSERT_AT(a_units_step, ((state_q == S_WB) && found_q) |=> (units_q == $past(units_q) + 32'd1))
  // An accepted arrival occupies the slot it was written to.
  `ASSERT_AT(a_arrive_fill, (in_fire && !s_axis_tuser_i && arrive_ok) |=> slot_valid_q[$past(free_idx)])
  // A finished result is never loaded over one that is still waiting.
  `ASSERT_AT(a_hold_beat, m_valid_q && !m_axis_tready_i |=> m_valid_q && $stable(m_axis_tdata_o))

endmodule
